// ----- design/gcab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcab_pkg
// Shared types, constants and arithmetic helpers for the glyph coverage
// alpha blender.
// ----------------------------------------------------------------------------
package gcab_pkg;

   // Full-scale channel value
   localparam logic [7:0] CHANNEL_MAX = 8'd255;

   // One divider cell per quotient bit
   localparam int CELL_COUNT = 8;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_TEXT_RED   = 2'd0;
   localparam csr_index_type CSR_TEXT_GREEN = 2'd1;
   localparam csr_index_type CSR_TEXT_BLUE  = 2'd2;

   // Incoming pixel, color lanes ordered red, green, blue
   typedef struct packed {
      logic [7:0]      old_alpha;
      logic [2:0][7:0] old_rgb;
      logic [7:0]      coverage;
   } pixel_in_type;

   // Item handed along the divider chain
   //   pix:  bypass color in lanes 0..2, final alpha (divisor) in lane 3
   //   rem:  running remainder per color lane
   //   quot: quotient bits collected so far, MSB first
   typedef struct packed {
      logic            bypass;
      logic [3:0][7:0] pix;
      logic [2:0][15:0] rem;
      logic [2:0][7:0] quot;
   } cell_data_type;

   // Exact floor(x / 255) for any 16-bit product of two 8-bit values
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// ----- design/glyph_coverage_alpha_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_coverage_alpha_blend
// Paints one glyph pixel into an RGBA destination with source-over blending.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one destination pixel plus its glyph coverage per item;
//   rsp_* returns the blended pixel, one item out for every item in, in order.
//   csr_* writes the text color (index 0 red, 1 green, 2 blue, 3 ignored);
//   it is always ready and should be written only while no item is in flight.
// Pipeline: an accepted item passes four front-end stages (products, divide
//   by 255 and new alpha, destination products, numerator) and a chain of
//   eight divider cells, one quotient bit each, dividing t * 255 by the new
//   alpha, before it shows on rsp_tvalid.
// Throughput: one item per clock; every stage and cell is its own register
//   slot, so a new item enters each cycle the chain can move.
// Stall: when rsp_tready is low the result holds in the last cell; upstream
//   stages keep filling empty slots, and req_tready drops once all twelve
//   slots hold items.
// Reset: synchronous, active high; clears all slots and the text color to 0.
// ----------------------------------------------------------------------------
module glyph_coverage_alpha_blend import gcab_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // coverage[7:0], old_red[15:8], old_green[23:16], old_blue[31:24],
   // old_alpha[39:32]
   input  logic [39:0]   req_tdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // new_red[7:0], new_green[15:8], new_blue[23:16], new_alpha[31:24]
   output logic [31:0]   rsp_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_data
);

   logic [7:0]      text_red_ff, text_red_in;
   logic [7:0]      text_green_ff, text_green_in;
   logic [7:0]      text_blue_ff, text_blue_in;
   logic [2:0][7:0] text_color;
   pixel_in_type    in_pix;

   logic [CELL_COUNT:0] cell_valid;
   logic [CELL_COUNT:0] cell_ready;
   cell_data_type       cell_data [CELL_COUNT:0];
   cell_data_type       last_data;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      text_red_in   = text_red_ff;
      text_green_in = text_green_ff;
      text_blue_in  = text_blue_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEXT_RED:   text_red_in   = csr_data;
            CSR_TEXT_GREEN: text_green_in = csr_data;
            CSR_TEXT_BLUE:  text_blue_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_red_ff   <= 8'd0;
         text_green_ff <= 8'd0;
         text_blue_ff  <= 8'd0;
      end else begin
         text_red_ff   <= text_red_in;
         text_green_ff <= text_green_in;
         text_blue_ff  <= text_blue_in;
      end
   end

   assign text_color = {text_blue_ff, text_green_ff, text_red_ff};

   // Unpack the incoming item
   assign in_pix.coverage   = req_tdata[7:0];
   assign in_pix.old_rgb[0] = req_tdata[15:8];
   assign in_pix.old_rgb[1] = req_tdata[23:16];
   assign in_pix.old_rgb[2] = req_tdata[31:24];
   assign in_pix.old_alpha  = req_tdata[39:32];

   // Blend front end
   gcab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pix     (in_pix),
      .text_color (text_color),
      .out_valid  (cell_valid[0]),
      .out_ready  (cell_ready[0]),
      .out_data   (cell_data[0])
   );

   // Divider chain, one quotient bit per cell
   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      gcab_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[c]),
         .in_ready  (cell_ready[c]),
         .in_data   (cell_data[c]),
         .out_valid (cell_valid[c+1]),
         .out_ready (cell_ready[c+1]),
         .out_data  (cell_data[c+1])
      );
   end

   assign cell_ready[CELL_COUNT] = rsp_tready;
   assign last_data              = cell_data[CELL_COUNT];

   // Result: bypass pixel or quotients with the new alpha
   assign rsp_tvalid = cell_valid[CELL_COUNT];
   assign rsp_tdata  = last_data.bypass ? last_data.pix
                     : {last_data.pix[3], last_data.quot[2], last_data.quot[1],
                        last_data.quot[0]};

   // Blended pixels always carry a nonzero alpha divisor
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !last_data.bypass |-> last_data.pix[3] != 8'd0)
      else $error("blended item reached output with zero alpha");

   // Input backpressure only when every divider slot is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> &cell_valid[CELL_COUNT:1])
      else $error("input stalled while divider chain has a free slot");

   // Nothing leaves right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid directly after reset");

   // A bypass result at the output never waits on a quotient: it equals pix
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && last_data.bypass |-> rsp_tdata == last_data.pix)
      else $error("bypass item did not pass its pixel through");

endmodule

// ----- design/gcab_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcab_front
// Four-stage blend front end: products, divide by 255, new alpha, and the
// blended numerator t * 255 for each color lane. Also picks bypass pixels.
// ----------------------------------------------------------------------------
module gcab_front import gcab_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  pixel_in_type    in_pix,
   input  logic [2:0][7:0] text_color,
   output logic            out_valid,
   input  logic            out_ready,
   output cell_data_type   out_data
);

   // Stage 1: raw products
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_bypass_ff, s1_bypass_in;
   logic [3:0][7:0]  s1_pix_ff, s1_pix_in;
   logic [7:0]       s1_cov_ff;
   logic [2:0][7:0]  s1_old_ff;
   logic [15:0]      s1_keep_prod_ff, s1_keep_prod_in;
   logic [2:0][15:0] s1_src_prod_ff, s1_src_prod_in;

   // Stage 2: keep, new alpha, source terms
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_bypass_ff;
   logic [3:0][7:0]  s2_pix_ff, s2_pix_in;
   logic [7:0]       s2_keep_ff, s2_keep_in;
   logic [2:0][7:0]  s2_src_term_ff, s2_src_term_in;
   logic [2:0][7:0]  s2_old_ff;
   logic [8:0]       s2_alpha_sum;

   // Stage 3: destination products
   logic             s3_valid_ff, s3_valid_in;
   logic             s3_bypass_ff;
   logic [3:0][7:0]  s3_pix_ff;
   logic [2:0][7:0]  s3_src_term_ff;
   logic [2:0][15:0] s3_old_prod_ff, s3_old_prod_in;

   // Stage 4: numerator for the divider chain
   logic             s4_valid_ff, s4_valid_in;
   cell_data_type    s4_data_ff, s4_data_in;
   logic [2:0][8:0]  s4_t_sum;

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   // Ready chain: a stage loads when empty or when it drains this cycle
   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   // Stage 1 logic: bypass selection and first products
   always_comb begin
      s1_bypass_in = (in_pix.coverage == 8'd0) || (in_pix.old_alpha == 8'd0);
      if (in_pix.coverage == 8'd0) begin
         // untouched pixel
         s1_pix_in = {in_pix.old_alpha, in_pix.old_rgb};
      end else if (in_pix.old_alpha == 8'd0) begin
         // empty destination takes the text color
         s1_pix_in = {in_pix.coverage, text_color};
      end else begin
         s1_pix_in = '0;
      end
      s1_keep_prod_in = 16'(in_pix.old_alpha) * 16'(CHANNEL_MAX - in_pix.coverage);
      for (int i = 0; i < 3; i++) begin
         s1_src_prod_in[i] = 16'(text_color[i]) * 16'(in_pix.coverage);
      end
   end

   // Stage 2 logic: divide by 255, new alpha
   always_comb begin
      s2_keep_in   = div255(s1_keep_prod_ff);
      s2_alpha_sum = {1'b0, s1_cov_ff} + {1'b0, s2_keep_in};
      s2_pix_in    = s1_pix_ff;
      if (!s1_bypass_ff) begin
         s2_pix_in[3] = s2_alpha_sum[7:0];
      end
      for (int i = 0; i < 3; i++) begin
         s2_src_term_in[i] = div255(s1_src_prod_ff[i]);
      end
   end

   // Stage 3 logic: destination weight products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_old_prod_in[i] = 16'(s2_old_ff[i]) * 16'(s2_keep_ff);
      end
   end

   // Stage 4 logic: t, then t * 255 as the dividend
   always_comb begin
      s4_data_in.bypass = s3_bypass_ff;
      s4_data_in.pix    = s3_pix_ff;
      s4_data_in.quot   = '0;
      for (int i = 0; i < 3; i++) begin
         s4_t_sum[i] = {1'b0, s3_src_term_ff[i]} + {1'b0, div255(s3_old_prod_ff[i])};
         s4_data_in.rem[i] = {s4_t_sum[i][7:0], 8'h00} - {8'h00, s4_t_sum[i][7:0]};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_bypass_ff    <= s1_bypass_in;
         s1_pix_ff       <= s1_pix_in;
         s1_cov_ff       <= in_pix.coverage;
         s1_old_ff       <= in_pix.old_rgb;
         s1_keep_prod_ff <= s1_keep_prod_in;
         s1_src_prod_ff  <= s1_src_prod_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_bypass_ff   <= s1_bypass_ff;
         s2_pix_ff      <= s2_pix_in;
         s2_keep_ff     <= s2_keep_in;
         s2_src_term_ff <= s2_src_term_in;
         s2_old_ff      <= s1_old_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_bypass_ff   <= s2_bypass_ff;
         s3_pix_ff      <= s2_pix_ff;
         s3_src_term_ff <= s2_src_term_ff;
         s3_old_prod_ff <= s3_old_prod_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// ----- design/gcab_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcab_div_cell
// One restoring-division cell: resolves one quotient bit on all three color
// lanes against the shared alpha, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module gcab_div_cell import gcab_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cell_data_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output cell_data_type out_data
);

   logic            valid_ff, valid_in;
   cell_data_type   data_ff, data_in;
   logic [15:0]     divisor;
   logic [2:0][15:0] diff;
   logic [2:0]      fits;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Divisor scaled to the top quotient bit; remainder shifts left per cell
   assign divisor = {1'b0, in_data.pix[3], 7'd0};

   // One quotient bit per lane
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         fits[i] = in_data.rem[i] >= divisor;
         diff[i] = fits[i] ? (in_data.rem[i] - divisor) : in_data.rem[i];
         data_in.rem[i]  = {diff[i][14:0], 1'b0};
         data_in.quot[i] = {in_data.quot[i][6:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- tb/glyph_coverage_alpha_blend_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_coverage_alpha_blend_tb
// Self-checking bench for the glyph coverage blender. A short table of
// directed pixels runs first at the reset text color, where the answers are
// obvious, and again with a new color. Then random pixels run under several
// text colors, checked item by item against a local model of the blend.
// Both stream sides idle and stall at random, except in one calm phase.
// ----------------------------------------------------------------------------
module glyph_coverage_alpha_blend_tb;
   import gcab_pkg::*;

   // Register slot past the three color registers, writes are dropped
   localparam csr_index_type CSR_SPARE = 2'd3;

   localparam int PHASE_ITEMS   = 200;
   localparam int RANDOM_PHASES = 7;
   localparam int DRAIN_CYCLES  = 30;
   localparam int REPORT_LIMIT  = 10;

   // Result pixel, packed as on rsp_tdata (red lowest)
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   // Directed row: fixed = expected value typed in, else predicted
   typedef struct packed {
      bit           fixed;
      rgba_type     want;
      pixel_in_type pix;
   } vector_type;

   // pix is {alpha, blue, green, red, coverage}; want is {alpha, blue, green, red}
   localparam int VECTOR_COUNT = 12;
   localparam vector_type VECTORS [VECTOR_COUNT] = '{
      {1'b1, 32'hff_ff_ff_ff, 40'hff_ff_ff_ff_00},  // zero coverage, all ones
      {1'b1, 32'h00_00_00_00, 40'h00_00_00_00_00},  // zero coverage, all zeros
      {1'b1, 32'h78_56_34_12, 40'h78_56_34_12_00},  // zero coverage keeps pixel
      {1'b1, 32'hff_00_00_00, 40'h00_ff_ff_ff_ff},  // empty dest, full coverage
      {1'b1, 32'h01_00_00_00, 40'h00_80_80_80_01},  // empty dest, faint coverage
      {1'b1, 32'hff_00_00_00, 40'hff_ff_ff_ff_ff},  // full coverage wins
      {1'b0, 32'h00_00_00_00, 40'hff_ff_ff_ff_01},
      {1'b0, 32'h00_00_00_00, 40'h01_ff_ff_ff_80},
      {1'b0, 32'h00_00_00_00, 40'h01_80_00_ff_01},
      {1'b0, 32'h00_00_00_00, 40'h80_0f_aa_55_80},
      {1'b0, 32'h00_00_00_00, 40'hfe_7f_fe_01_7f},
      {1'b0, 32'h00_00_00_00, 40'h01_ff_ff_ff_fe}
   };

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic [39:0]   req_tdata  = '0;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   wire  [31:0]   rsp_tdata;
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_valid  = 1'b0;
   wire           csr_ready;
   csr_index_type csr_index  = CSR_TEXT_RED;
   logic [7:0]    csr_data   = '0;

   // Local copy of the text color, lanes red, green, blue
   logic [7:0] text_rgb [3];

   rgba_type pending_pixels [$];
   int       mismatches = 0;
   logic     calm       = 1'b0;
   int       ready_hold = 0;

   glyph_coverage_alpha_blend dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One color lane: source over, then divide back by the new alpha
   function automatic logic [7:0] mix_channel(logic [7:0] src, logic [7:0] cov,
                                              logic [7:0] old, int unsigned keep,
                                              int unsigned new_alpha);
      int unsigned s;
      int unsigned c;
      int unsigned o;
      int unsigned t;
      s = src;
      c = cov;
      o = old;
      t = (s * c) / CHANNEL_MAX + (o * keep) / CHANNEL_MAX;
      t = t & 8'hff;
      if (new_alpha == 0)
         return t[7:0];
      return 8'((t * CHANNEL_MAX) / new_alpha);
   endfunction

   // Expected destination pixel for one glyph pixel at the current color
   function automatic rgba_type blend_pixel(pixel_in_type p);
      rgba_type    r;
      int unsigned cov;
      int unsigned dst_alpha;
      int unsigned keep;
      int unsigned new_alpha;
      cov       = p.coverage;
      dst_alpha = p.old_alpha;
      if (cov == 0) begin
         r.red   = p.old_rgb[0];
         r.green = p.old_rgb[1];
         r.blue  = p.old_rgb[2];
         r.alpha = p.old_alpha;
      end else if (dst_alpha == 0) begin
         r.red   = text_rgb[0];
         r.green = text_rgb[1];
         r.blue  = text_rgb[2];
         r.alpha = p.coverage;
      end else begin
         keep      = (dst_alpha * (CHANNEL_MAX - cov)) / CHANNEL_MAX;
         new_alpha = (cov + keep) & 8'hff;
         r.red   = mix_channel(text_rgb[0], p.coverage, p.old_rgb[0], keep, new_alpha);
         r.green = mix_channel(text_rgb[1], p.coverage, p.old_rgb[1], keep, new_alpha);
         r.blue  = mix_channel(text_rgb[2], p.coverage, p.old_rgb[2], keep, new_alpha);
         r.alpha = new_alpha[7:0];
      end
      return r;
   endfunction

   // Color value with extra weight on the extremes
   function automatic logic [7:0] pick_channel();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pixel_in_type random_pixel();
      pixel_in_type p;
      int unsigned  r;
      r = $urandom_range(0, 19);
      if (r < 3)
         p.coverage = 8'h00;
      else if (r < 6)
         p.coverage = 8'hff;
      else if (r == 6)
         p.coverage = 8'h01;
      else if (r == 7)
         p.coverage = 8'hfe;
      else
         p.coverage = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (r < 3)
         p.old_alpha = 8'h00;
      else if (r < 6)
         p.old_alpha = 8'hff;
      else if (r == 6)
         p.old_alpha = 8'h01;
      else
         p.old_alpha = 8'($urandom_range(0, 255));
      p.old_rgb[0] = pick_channel();
      p.old_rgb[1] = pick_channel();
      p.old_rgb[2] = pick_channel();
      return p;
   endfunction

   // Sender gap: mostly none, some short, a few long
   function automatic int pick_gap(bit quiet);
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Write one register and track it in the local color copy
   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEXT_RED:   text_rgb[0] = value;
         CSR_TEXT_GREEN: text_rgb[1] = value;
         CSR_TEXT_BLUE:  text_rgb[2] = value;
         default: ;
      endcase
   endtask

   // Full color update, with a junk write to the spare slot first
   task automatic set_text_color(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      write_csr(CSR_SPARE, 8'($urandom_range(0, 255)));
      write_csr(CSR_TEXT_RED, red);
      write_csr(CSR_TEXT_GREEN, green);
      write_csr(CSR_TEXT_BLUE, blue);
      csr_valid <= 1'b0;
   endtask

   // Offer one pixel after an optional gap, wait for the handshake
   task automatic drive_pixel(pixel_in_type p, rgba_type want, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= p;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(want);
   endtask

   // Stop sending and wait until every expected pixel came back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Result side back-pressure
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 30);
      end
   end

   // Result checker
   always @(posedge clock) begin
      rgba_type got;
      rgba_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("tb: unexpected result %h", got);
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("tb: mismatch rgba expected %h %h %h %h got %h %h %h %h",
                           want.red, want.green, want.blue, want.alpha,
                           got.red, got.green, got.blue, got.alpha);
            end
         end
      end
   end

   // Stimulus
   initial begin
      pixel_in_type p;
      vector_type   v;
      int           n;
      int           ph;
      text_rgb[0] = 8'h00;
      text_rgb[1] = 8'h00;
      text_rgb[2] = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset color, typed answers where obvious
      for (n = 0; n < VECTOR_COUNT; n++) begin
         v = VECTORS[n];
         drive_pixel(v.pix, v.fixed ? v.want : blend_pixel(v.pix), pick_gap(1'b0));
      end
      drain_results();

      // Same table with a mixed color, all predicted
      set_text_color(8'hff, 8'h00, 8'h80);
      for (n = 0; n < VECTOR_COUNT; n++) begin
         v = VECTORS[n];
         drive_pixel(v.pix, blend_pixel(v.pix), pick_gap(1'b0));
      end
      drain_results();

      // Random pixels under several colors, extremes first
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: set_text_color(8'hff, 8'hff, 8'hff);
            1: set_text_color(8'h00, 8'h00, 8'h00);
            2: set_text_color(8'h00, 8'hff, 8'h01);
            default: set_text_color(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
         endcase
         calm <= (ph == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // one full pause mid-run until the pipe empties
            if (ph == 1 && n == PHASE_ITEMS / 2)
               drain_results();
            p = random_pixel();
            drive_pixel(p, blend_pixel(p), pick_gap(ph == 3));
         end
         drain_results();
      end
      calm <= 1'b0;

      // Catch any stray result past the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
design/gcab_pkg.sv
design/gcab_front.sv
design/gcab_div_cell.sv
design/glyph_coverage_alpha_blend.sv
tb/glyph_coverage_alpha_blend_tb.sv
